/* rtl/rrss_pkg.sv */
// Shared types and constants for the record rank, sort and search block.
// Used by every module in rtl; depends on nothing.
package rrss_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int ID_W   = 16;
  localparam int MARK_W = 7;
  localparam int KEY_W  = 7;
  localparam int SUM_W  = 9;

  // floor(sum / 3) for sum below 512 is (sum * 171) >> 9.
  localparam int KEY_RECIP = 171;
  localparam int KEY_SHIFT = 9;
  localparam int PROD_W    = 17;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_RANK   = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MARK_W-1:0] mark_c;
    logic [MARK_W-1:0] mark_b;
    logic [MARK_W-1:0] mark_a;
    logic [ID_W-1:0]   id;
  } rec_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD_I,
    ST_SORT_LD_I,
    ST_SORT_RD_J,
    ST_SORT_CMP,
    ST_SORT_EMIT,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SRCH_FIN
  } state_t;

endpackage

/* rtl/rrss_key.sv */
// Key unit: the three-mark sum divided by three through a reciprocal multiply.
// Depends on rrss_pkg.
module rrss_key
  import rrss_pkg::*;
(
  input  logic [MARK_W-1:0] mark_a,
  input  logic [MARK_W-1:0] mark_b,
  input  logic [MARK_W-1:0] mark_c,
  output logic [KEY_W-1:0]  key
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sum  = SUM_W'(mark_a) + SUM_W'(mark_b) + SUM_W'(mark_c);
  assign prod = PROD_W'(sum) * PROD_W'(KEY_RECIP);
  assign key  = prod[KEY_SHIFT +: KEY_W];

endmodule

/* rtl/rrss_cmp.sv */
// Shared compare unit: key ordering during the sort and id match during search.
// Depends on rrss_pkg.
module rrss_cmp
  import rrss_pkg::*;
(
  input  logic [ID_W-1:0] opa,
  input  logic [ID_W-1:0] opb,
  output cmp_res_t        res
);

  assign res.gt = (opa > opb);
  assign res.eq = (opa == opb);

endmodule

/* rtl/rrss_mem.sv */
// Record table: one write port and one read port with registered read data.
// Depends on rrss_pkg.
module rrss_mem
  import rrss_pkg::*;
#(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/record_rank_sort_search.sv */
// Top level of the record table with exchange-sort ranking and id search.
// Depends on rrss_pkg, rrss_key, rrss_cmp and rrss_mem.
//
// Adds may follow back to back; the key is computed and stored with the record.
// A rank or search sends every record through the single registered read port
// of the table and through one shared comparator, and stalls on the result
// side hold it up. The input is not ready while a rank or search is running.
// The table needs no clearing pass after reset.
module record_rank_sort_search
  import rrss_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // record_id, mark_a, mark_b, mark_c
  input  logic [1:0]            in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_id, out_mark_a, out_mark_b, out_mark_c, out_key
  output logic                  out_tlast
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  rec_t            cur_r, cur_nxt;
  rec_t            pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [ID_W-1:0] sid_r, sid_nxt;

  logic            out_valid_r;
  rec_t            out_rec_r;
  logic            out_last_r;

  logic            accept;
  logic            out_free;
  logic            i_is_last;
  logic            j_is_last;
  logic [CW-1:0]   cnt_m1;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  rec_t            mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  rec_t            mem_rdata;

  logic [ID_W-1:0] cmp_a;
  logic [ID_W-1:0] cmp_b;
  cmp_res_t        cmp_res;

  rec_t            add_rec;
  logic [KEY_W-1:0] add_key;

  logic            out_load;
  rec_t            out_ld_rec;
  logic            out_ld_last;
  logic            srch_stall;

  assign accept   = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = ~out_valid_r | out_tready;
  assign cnt_m1   = cnt_r - CW'(1);
  assign i_is_last = (CW'(i_r) == cnt_m1);
  assign j_is_last = (CW'(j_r) == cnt_m1);
  assign srch_stall = cmp_res.eq & pend_v_r & ~out_free;

  rrss_key u_key (
    .mark_a (in_tdata[22:16]),
    .mark_b (in_tdata[29:23]),
    .mark_c (in_tdata[36:30]),
    .key    (add_key)
  );

  always_comb begin
    add_rec.id     = in_tdata[15:0];
    add_rec.mark_a = in_tdata[22:16];
    add_rec.mark_b = in_tdata[29:23];
    add_rec.mark_c = in_tdata[36:30];
    add_rec.key    = add_key;
  end

  rrss_cmp u_cmp (
    .opa (cmp_a),
    .opb (cmp_b),
    .res (cmp_res)
  );

  rrss_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && cnt_r != '0) begin
          if (in_tuser == KIND_RANK) begin
            state_nxt = ST_SORT_RD_I;
          end else if (in_tuser == KIND_SEARCH) begin
            state_nxt = ST_SRCH_RD;
          end
        end
      end
      ST_SORT_RD_I: state_nxt = ST_SORT_LD_I;
      ST_SORT_LD_I: state_nxt = i_is_last ? ST_SORT_EMIT : ST_SORT_RD_J;
      ST_SORT_RD_J: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP:  state_nxt = j_is_last ? ST_SORT_EMIT : ST_SORT_RD_J;
      ST_SORT_EMIT: begin
        if (out_free) begin
          state_nxt = i_is_last ? ST_IDLE : ST_SORT_RD_I;
        end
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (!srch_stall) begin
          state_nxt = j_is_last ? ST_SRCH_FIN : ST_SRCH_RD;
        end
      end
      ST_SRCH_FIN: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cur_nxt     = cur_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    sid_nxt     = sid_r;
    mem_we      = 1'b0;
    mem_waddr   = i_r;
    mem_wdata   = cur_r;
    mem_re      = 1'b0;
    mem_raddr   = j_r;
    cmp_a       = {{(ID_W-KEY_W){1'b0}}, mem_rdata.key};
    cmp_b       = {{(ID_W-KEY_W){1'b0}}, cur_r.key};
    out_load    = 1'b0;
    out_ld_rec  = cur_r;
    out_ld_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt      = '0;
        j_nxt      = '0;
        pend_v_nxt = 1'b0;
        sid_nxt    = in_tdata[15:0];
        if (accept && in_tuser == KIND_ADD && cnt_r < CW'(MAX_ENTRIES)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata = add_rec;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      ST_SORT_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
      end
      ST_SORT_LD_I: begin
        cur_nxt = mem_rdata;
        j_nxt   = i_r + AW'(1);
      end
      ST_SORT_RD_J: begin
        mem_re = 1'b1;
      end
      ST_SORT_CMP: begin
        if (cmp_res.gt) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          cur_nxt   = mem_rdata;
        end
        j_nxt = j_r + AW'(1);
      end
      ST_SORT_EMIT: begin
        if (out_free) begin
          mem_we      = 1'b1;
          out_load    = 1'b1;
          out_ld_last = i_is_last;
          i_nxt       = i_r + AW'(1);
        end
      end
      ST_SRCH_RD: begin
        mem_re = 1'b1;
      end
      ST_SRCH_CHK: begin
        cmp_a      = mem_rdata.id;
        cmp_b      = sid_r;
        out_ld_rec = pend_r;
        if (!srch_stall) begin
          if (cmp_res.eq) begin
            out_load   = pend_v_r;
            pend_nxt   = mem_rdata;
            pend_v_nxt = 1'b1;
          end
          j_nxt = j_r + AW'(1);
        end
      end
      ST_SRCH_FIN: begin
        out_ld_rec  = pend_r;
        out_ld_last = 1'b1;
        if (pend_v_r && out_free) begin
          out_load   = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    sid_r  <= sid_nxt;
    if (out_load) begin
      out_rec_r  <= out_ld_rec;
      out_last_r <= out_ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(rec_t)){1'b0}}, out_rec_r};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("record count exceeds table depth");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r != '0)
    else $error("walk running over an empty table");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |=> cnt_r == $past(cnt_r))
    else $error("record count changed during a walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register loaded while a transfer is pending");
`endif

endmodule

/* verif/record_rank_sort_search_tb.sv */
// Testbench for record_rank_sort_search: directed and random add, rank and search
// transfers with random idling on both sides, each record checked against a predictor.
// Depends on rrss_pkg and the RTL top level record_rank_sort_search.
module record_rank_sort_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrss_pkg::*;

  localparam int TB_ENTRIES = MAX_ENTRIES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 50;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int UNTYPED = -1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MARK_W-1:0] a, b, c;
  } entry_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [MARK_W-1:0] a, b, c;
    logic [KEY_W-1:0]  key;
    logic              last;
  } ranked_rec_t;

  typedef struct {
    logic [1:0]        kind;
    logic [ID_W-1:0]   rec_id;
    logic [MARK_W-1:0] ma, mb, mc;
    int                n_typed;
    logic [ID_W-1:0]   first_id;
    logic [KEY_W-1:0]  first_key;
  } stim_row_t;

  typedef struct {
    int               n_typed;
    logic [ID_W-1:0]  first_id;
    logic [KEY_W-1:0] first_key;
  } typed_exp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // record_id, mark_a, mark_b, mark_c
  logic [1:0]            in_tuser = '0;   // kind
  logic                  out_tready = 1'b0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;       // out_id, out_mark_a, out_mark_b, out_mark_c, out_key
  wire                   out_tlast;

  record_rank_sort_search #(
    .MAX_ENTRIES(TB_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: a copy of the record table and what it must emit next.
  entry_t      shadow_table [TB_ENTRIES];
  int          shadow_count = 0;
  ranked_rec_t expected_recs [$];
  typed_exp_t  typed_q [$];

  int error_count = 0;
  int items_accepted = 0;
  int records_checked = 0;
  int rank_count = 0;
  int search_count = 0;
  int dropped_adds = 0;

  function automatic logic [KEY_W-1:0] key_of(entry_t e);
    int s;
    s = e.a + e.b + e.c;
    return KEY_W'(s / 3);
  endfunction

  function automatic void push_record(entry_t e, logic is_last);
    ranked_rec_t r;
    r.id = e.id;
    r.a = e.a;
    r.b = e.b;
    r.c = e.c;
    r.key = key_of(e);
    r.last = is_last;
    expected_recs.push_back(r);
  endfunction

  task automatic predict_transfer(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                  input logic [MARK_W-1:0] a, b, c, output int n_res);
    entry_t tmp;
    int last_match;
    n_res = 0;
    case (kind)
      KIND_ADD: begin
        if (shadow_count < TB_ENTRIES) begin
          shadow_table[shadow_count] = '{id, a, b, c};
          shadow_count++;
        end else begin
          dropped_adds++;
        end
      end
      KIND_RANK: begin
        rank_count++;
        for (int i = 0; i < shadow_count; i++) begin
          for (int j = i + 1; j < shadow_count; j++) begin
            if (key_of(shadow_table[j]) > key_of(shadow_table[i])) begin
              tmp = shadow_table[i];
              shadow_table[i] = shadow_table[j];
              shadow_table[j] = tmp;
            end
          end
        end
        for (int i = 0; i < shadow_count; i++) begin
          push_record(shadow_table[i], i == shadow_count - 1);
          n_res++;
        end
      end
      KIND_SEARCH: begin
        search_count++;
        last_match = -1;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_table[i].id == id) last_match = i;
        end
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_table[i].id == id) begin
            push_record(shadow_table[i], i == last_match);
            n_res++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Input transfers feed the predictor first, so a result accepted at the same
  // edge still finds the expectations of earlier items at the head of the queue.
  always @(posedge clk) begin
    typed_exp_t  te;
    ranked_rec_t want;
    ranked_rec_t got;
    int          n;
    int          base;
    if (rst_n && in_tvalid && in_tready) begin
      base = expected_recs.size();
      predict_transfer(in_tuser, in_tdata[15:0], in_tdata[22:16], in_tdata[29:23],
                       in_tdata[36:30], n);
      items_accepted++;
      if (typed_q.size() > 0) begin
        te = typed_q.pop_front();
        if (te.n_typed != UNTYPED) begin
          if (n != te.n_typed) begin
            error_count++;
            $display("%0t: item %0d expected %0d records, predicted %0d",
                     $time, items_accepted, te.n_typed, n);
          end else if (n > 0 && (expected_recs[base].id != te.first_id ||
                                 expected_recs[base].key != te.first_key)) begin
            error_count++;
            $display("%0t: item %0d first record expected id %h key %0d, predicted id %h key %0d",
                     $time, items_accepted, te.first_id, te.first_key,
                     expected_recs[base].id, expected_recs[base].key);
          end
        end
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.id = out_tdata[15:0];
      got.a = out_tdata[22:16];
      got.b = out_tdata[29:23];
      got.c = out_tdata[36:30];
      got.key = out_tdata[43:37];
      got.last = out_tlast;
      if (expected_recs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected record id %h a %0d b %0d c %0d key %0d last %0b",
                 $time, got.id, got.a, got.b, got.c, got.key, got.last);
      end else begin
        want = expected_recs.pop_front();
        records_checked++;
        if (got.id !== want.id || got.a !== want.a || got.b !== want.b ||
            got.c !== want.c || got.key !== want.key || got.last !== want.last) begin
          error_count++;
          $display("%0t: record mismatch, expected id %h a %0d b %0d c %0d key %0d last %0b",
                   $time, want.id, want.a, want.b, want.c, want.key, want.last,
                   ", got id %h a %0d b %0d c %0d key %0d last %0b",
                   got.id, got.a, got.b, got.c, got.key, got.last);
        end
      end
    end
  end

  stim_row_t directed_rows [20] = '{
    '{KIND_RANK,   16'h0000,   7'd0,   7'd0,   7'd0, 0, 16'h0000,   7'd0},
    '{KIND_SEARCH, 16'h0000,   7'd0,   7'd0,   7'd0, 0, 16'h0000,   7'd0},
    '{KIND_UNUSED, 16'hffff, 7'd127, 7'd127, 7'd127, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h0000,   7'd0,   7'd0,   7'd0, 0, 16'h0000,   7'd0},
    '{KIND_SEARCH, 16'h0000, 7'd127, 7'd127, 7'd127, 1, 16'h0000,   7'd0},
    '{KIND_ADD,    16'hffff, 7'd100, 7'd100, 7'd100, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h1234, 7'd127, 7'd127, 7'd127, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h00ff,   7'd1,   7'd1,   7'd0, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h5555,   7'd2,   7'd2,   7'd1, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'haaaa,  7'd50,  7'd50,  7'd51, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h5555,  7'd99, 7'd100, 7'd100, 0, 16'h0000,   7'd0},
    '{KIND_SEARCH, 16'h5555,   7'd0,   7'd0,   7'd0, 2, 16'h5555,   7'd1},
    '{KIND_SEARCH, 16'h7777, 7'd127, 7'd127, 7'd127, 0, 16'h0000,   7'd0},
    '{KIND_RANK,   16'hffff, 7'd127, 7'd127, 7'd127, 7, 16'h1234, 7'd127},
    '{KIND_SEARCH, 16'h5555,  7'd85,  7'd42,   7'd3, 2, 16'h5555,  7'd99},
    '{KIND_UNUSED, 16'h0f0f,  7'd10,  7'd20,  7'd30, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h0001,  7'd33,  7'd33,  7'd34, 0, 16'h0000,   7'd0},
    '{KIND_ADD,    16'h0002,  7'd34,  7'd33,  7'd33, 0, 16'h0000,   7'd0},
    '{KIND_RANK,   16'h0000,   7'd0,   7'd0,   7'd0, 9, 16'h1234, 7'd127},
    '{KIND_SEARCH, 16'hffff,   7'd0,   7'd0,   7'd0, 1, 16'hffff, 7'd100}
  };

  // Sender bookkeeping, kept apart from the predictor so that picking ids
  // never races with the monitor.
  logic [ID_W-1:0] sent_ids [$];
  int              sent_adds = 0;
  int              sent_items = 0;

  task automatic offer(input stim_row_t row);
    int gap;
    gap = ((sent_items / 16) % 3 == 2) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back(typed_exp_t'{row.n_typed, row.first_id, row.first_key});
    in_tvalid <= 1'b1;
    in_tuser <= row.kind;
    in_tdata <= {3'b000, row.mc, row.mb, row.ma, row.rec_id};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    if (row.kind == KIND_ADD) begin
      sent_adds++;
      if (sent_ids.size() < TB_ENTRIES) sent_ids.push_back(row.rec_id);
    end
  endtask

  function automatic logic [MARK_W-1:0] draw_mark();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return MARK_W'($urandom_range(101, 127));
    if (r <= 2) return MARK_W'($urandom_range(40, 45));
    return MARK_W'($urandom_range(0, 100));
  endfunction

  task automatic make_add_row(output stim_row_t row);
    row.kind = KIND_ADD;
    if (sent_ids.size() > 0 && $urandom_range(0, 2) == 0)
      row.rec_id = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
    else
      row.rec_id = ID_W'($urandom());
    row.ma = draw_mark();
    row.mb = draw_mark();
    row.mc = draw_mark();
    row.n_typed = UNTYPED;
    row.first_id = '0;
    row.first_key = '0;
  endtask

  task automatic make_random_row(output stim_row_t row);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      make_add_row(row);
    end else begin
      row.kind = (r < 66) ? KIND_RANK : (r < 95) ? KIND_SEARCH : KIND_UNUSED;
      row.rec_id = ID_W'($urandom());
      if (row.kind == KIND_SEARCH && sent_ids.size() > 0 && $urandom_range(0, 4) != 0)
        row.rec_id = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
      row.ma = MARK_W'($urandom());
      row.mb = MARK_W'($urandom());
      row.mc = MARK_W'($urandom());
      row.n_typed = UNTYPED;
      row.first_id = '0;
      row.first_key = '0;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (expected_recs.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    stim_row_t       row;
    logic [ID_W-1:0] dropped_id;
    dropped_id = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i]);
    in_tvalid <= 1'b0;
    wait_drained();

    repeat (RANDOM_ITEMS) begin
      make_random_row(row);
      offer(row);
    end

    // Fill the table, then push a few adds that must be dropped.
    while (sent_adds < TB_ENTRIES + 3) begin
      make_add_row(row);
      if (sent_adds >= TB_ENTRIES) begin
        row.rec_id = ID_W'($urandom());
        dropped_id = row.rec_id;
      end
      offer(row);
    end
    row.kind = KIND_SEARCH;
    row.rec_id = dropped_id;
    offer(row);
    row.rec_id = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
    offer(row);
    row.kind = KIND_RANK;
    offer(row);
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transfers in (%0d ranks, %0d searches, %0d adds dropped when full),",
             items_accepted, rank_count, search_count, dropped_adds);
    $display("%0d records checked, table held %0d entries at the end.",
             records_checked, shadow_count);
    if (error_count == 0 && expected_recs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls per record, plus one long hold early in the run
  // so the block backs up and stalls its input.
  initial begin
    int gap;
    int got;
    bit held;
    got = 0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && got >= 10) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = ((got / 20) % 3 == 1) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got++;
    end
  end

  initial begin
    #50_000_000;
    $display("%0t: timeout with %0d records still expected", $time, expected_recs.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
